### hw/rtl/pwlm_pkg.sv
// Package for the word lookup mixer: item types, moduli table, sizes.
// Used by every file under hw/rtl except pwlm_ram.
package pwlm_pkg;
	localparam int WordCount = 65536;
	localparam int IdxW = $clog2(WordCount);
	localparam int WordW = 256;
	localparam logic [16:0] HornMod = 17'(WordCount - 1);

	typedef struct packed {
		logic [63:0] nonce_part3;
		logic [63:0] nonce_part2;
		logic [63:0] nonce_part1;
		logic [63:0] nonce_part0;
		logic [63:0] store_data3;
		logic [63:0] store_data2;
		logic [63:0] store_data1;
		logic [63:0] store_data0;
		logic [15:0] word_index;
		logic        kind;
	} in_item_t;

	typedef struct packed {
		logic        words_distinct;
		logic        meets_target;
		logic [63:0] mix_part3;
		logic [63:0] mix_part2;
		logic [63:0] mix_part1;
		logic [63:0] mix_part0;
	} out_item_t;

	localparam logic KindLoad = 1'b0;
	localparam logic KindEval = 1'b1;

	localparam logic [2:0] CfgHash0 = 3'd0;
	localparam logic [2:0] CfgTarget0 = 3'd4;

	function automatic logic [15:0] modulus(input logic [3:0] i);
		logic [15:0] m;
		case (i)
			4'd0: m = 16'hfffd;
			4'd1: m = 16'hfffb;
			4'd2: m = 16'hfff7;
			4'd3: m = 16'hfff1;
			4'd4: m = 16'hffef;
			4'd5: m = 16'hffe5;
			4'd6: m = 16'hffdf;
			4'd7: m = 16'hffd9;
			4'd8: m = 16'hffd3;
			4'd9: m = 16'hffd1;
			default: m = 16'hfffd;
		endcase
		return m;
	endfunction
endpackage

### hw/rtl/pwlm_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module pwlm_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0]         wdata,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) mem_q[addr] <= wdata;
		rdata <= mem_q[addr];
	end
endmodule

### hw/rtl/pwlm_modred.sv
// Shared residue unit: reduces a 32-bit value modulo an m just below 2^16 by
// folding the upper half with 2^16 mod m twice, then one compare and subtract.
// Depends on pwlm_pkg. res is valid while done is high; go is staged via run_s1, run_s2.
module pwlm_modred import pwlm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        go,
	input  logic [31:0] val,
	input  logic [16:0] m,
	output logic        done,
	output logic [16:0] res
);
	logic [31:0] v_s1;
	logic [16:0] m_s1;
	logic [21:0] t_s2;
	logic [16:0] m_s2;
	logic        run_s1;
	logic        run_s2;
	logic [16:0] cdiff1;
	logic [16:0] cdiff2;
	logic [21:0] fold1;
	logic [16:0] fold2;
	logic [17:0] df;

	always_comb begin
		cdiff1 = 17'h1_0000 - m_s1;
		fold1 = 22'(v_s1[31:16]) * 22'(cdiff1[5:0]) + 22'(v_s1[15:0]);
		cdiff2 = 17'h1_0000 - m_s2;
		fold2 = 17'(t_s2[21:16]) * 17'(cdiff2[5:0]) + 17'(t_s2[15:0]);
		df = {1'b0, fold2} - {1'b0, m_s2};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_s1 <= 1'b0;
			run_s2 <= 1'b0;
		end else begin
			run_s1 <= go;
			run_s2 <= run_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			v_s1 <= val;
			m_s1 <= m;
		end
		if (run_s1) begin
			t_s2 <= fold1;
			m_s2 <= m_s1;
		end
	end

	assign done = run_s2;
	assign res = df[17] ? fold2 : df[16:0];
endmodule

### hw/rtl/pow_word_lookup_mixer.sv
// Word lookup mixer top level: loads store words and evaluates nonces.
// Uses pwlm_pkg, pwlm_ram and the shared residue unit pwlm_modred.
//
// Channels: an item is taken when start is high and busy is low. A load
// item writes one 256-bit word and gives no result. An evaluate item gives
// one result on result_item, marked by done for one cycle; the receiver
// cannot hold it off. Configuration writes (cfg_we, cfg_index, cfg_data)
// take effect at once; the user must make them only while busy is low, as
// the block does not enforce it. A load item holds busy only in S_LOAD.
// An evaluate item runs every residue and Horner step through one residue
// unit: 5 coefficient and 10 hash residues of 16 steps each, 40 Horner
// steps, then 10 store reads, each compared with every earlier word. done
// is high in S_OUT; the next item can be taken in the cycle after done, and
// no new item is taken before the last one is through. The shared residue
// unit sets the pace.
// Reset clears the sequencer and the configuration registers; store
// contents are undefined until written.
module pow_word_lookup_mixer import pwlm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  in_item_t  item,
	output logic      busy,
	input  logic      cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [63:0] cfg_data,
	output logic      done,
	output out_item_t result_item
);
	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001, S_LOAD = 8'b0000_0010, S_RES = 8'b0000_0100,
		S_HORN = 8'b0000_1000, S_RD = 8'b0001_0000, S_WAIT = 8'b0010_0000,
		S_CMP = 8'b0100_0000, S_OUT = 8'b1000_0000
	} state_t;

	state_t       state_q;
	logic [255:0] hash_q, target_q, nonce_q, mix_q;
	logic [16:0]  cf_q [5];
	logic [16:0]  idx_q [10];
	logic [16:0]  acc_q;
	logic [3:0]   sel_q;     // residue / lookup number
	logic [3:0]   dig_q;     // digit or Horner step
	logic [3:0]   cmp_q;
	logic         distinct_q;
	logic [15:0]  item_idx_q;
	logic         running_q, phase_q;
	logic [255:0] words_q [10];
	logic [255:0] rdata;
	logic         go;
	logic [31:0]  val;
	logic [16:0]  m;
	logic         mdone;
	logic [16:0]  mres;
	logic         ram_we;
	logic [IdxW-1:0] ram_addr;
	logic [255:0] src;
	logic [33:0]  prod;

	pwlm_ram #(.Width(WordW), .Depth(WordCount)) u_ram (
		.clk(clk), .we(ram_we), .addr(ram_addr),
		.wdata(nonce_q), .rdata(rdata)
	);

	pwlm_modred u_mod (
		.clk(clk), .arst_n(arst_n), .go(go), .val(val), .m(m),
		.done(mdone), .res(mres)
	);

	assign busy = state_q != S_IDLE;
	assign src = (sel_q < 4'd5 && !phase_q) ? nonce_q : hash_q;

	// residue phase: sel 0..4 nonce coefficients (phase_q=0), then sel 0..9 hash; also Horner steps and store writes
	always_comb begin
		go = 1'b0;
		val = '0;
		m = '0;
		prod = 34'(acc_q) * 34'(idx_q[sel_q]);
		ram_we = 1'b0;
		ram_addr = idx_q[sel_q][IdxW-1:0];
		if (state_q == S_RES) begin
			m = {1'b0, modulus(sel_q)};
			val = {acc_q[15:0], src[255 - 16*dig_q -: 16]};
			go = !running_q;
		end else if (state_q == S_HORN) begin
			m = HornMod;
			val = prod[31:0] + 32'(cf_q[3'd3 - dig_q[2:0]]);
			go = !running_q;
		end
		if (state_q == S_LOAD) begin
			ram_we = 32'(item_idx_q) < 32'(WordCount);
			ram_addr = IdxW'(item_idx_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			hash_q <= '0;
			target_q <= '0;
			running_q <= 1'b0;
			phase_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index < CfgTarget0) hash_q[64*cfg_index[1:0] +: 64] <= cfg_data;
				else target_q[64*cfg_index[1:0] +: 64] <= cfg_data;
			end
			case (state_q)
				S_IDLE: if (start) begin
					state_q <= item.kind == KindLoad ? S_LOAD : S_RES;
					running_q <= 1'b0;
					phase_q <= 1'b0;
				end
				S_LOAD: state_q <= S_IDLE;
				S_RES: if (!running_q) running_q <= 1'b1;
					else if (mdone) begin
						running_q <= 1'b0;
						if (dig_q == 4'd15) begin
							if (!phase_q && sel_q == 4'd4) phase_q <= 1'b1;
							else if (phase_q && sel_q == 4'd9) state_q <= S_HORN;
						end
					end
				S_HORN: if (!running_q) running_q <= 1'b1;
					else if (mdone) begin
						running_q <= 1'b0;
						if (dig_q == 4'd3 && sel_q == 4'd9) state_q <= S_RD;
					end
				S_RD: state_q <= S_WAIT;
				S_WAIT: state_q <= S_CMP;
				S_CMP: if (cmp_q == sel_q) state_q <= sel_q == 4'd9 ? S_OUT : S_RD;
				S_OUT: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: if (start) begin
				item_idx_q <= item.word_index;
				nonce_q <= item.kind == KindLoad
					? {item.store_data3, item.store_data2, item.store_data1, item.store_data0}
					: {item.nonce_part3, item.nonce_part2, item.nonce_part1, item.nonce_part0};
				sel_q <= '0;
				dig_q <= '0;
				acc_q <= '0;
				distinct_q <= 1'b1;
			end
			S_RES: if (running_q && mdone) begin
				if (dig_q == 4'd15) begin
					dig_q <= '0;
					if (!phase_q) cf_q[sel_q[2:0]] <= mres + 17'd1;
					else idx_q[sel_q] <= mres;
					sel_q <= (!phase_q && sel_q == 4'd4) || sel_q == 4'd9 ? 4'd0 : sel_q + 4'd1;
					if (phase_q && sel_q == 4'd9) acc_q <= cf_q[4];
					else acc_q <= '0;
				end else begin
					dig_q <= dig_q + 4'd1;
					acc_q <= mres;
				end
			end
			S_HORN: if (running_q && mdone) begin
				if (dig_q == 4'd3) begin
					dig_q <= '0;
					idx_q[sel_q] <= mres;
					sel_q <= sel_q == 4'd9 ? 4'd0 : sel_q + 4'd1;
					acc_q <= cf_q[4];
					mix_q <= hash_q;
				end else begin
					dig_q <= dig_q + 4'd1;
					acc_q <= mres;
				end
			end
			S_RD: cmp_q <= '0;
			S_WAIT: begin
				words_q[sel_q] <= rdata;
				mix_q <= mix_q ^ rdata;
			end
			S_CMP: begin
				if (cmp_q != sel_q && words_q[cmp_q] == words_q[sel_q]) distinct_q <= 1'b0;
				if (cmp_q != sel_q) cmp_q <= cmp_q + 4'd1;
				else if (sel_q != 4'd9) sel_q <= sel_q + 4'd1;
			end
			default: ;
		endcase
	end

	assign done = state_q == S_OUT;
	assign result_item = '{words_distinct: distinct_q, meets_target: mix_q <= target_q,
		mix_part3: mix_q[255:192], mix_part2: mix_q[191:128],
		mix_part1: mix_q[127:64], mix_part0: mix_q[63:0]};
endmodule

### hw/rtl/pwlm_checker.sv
// Port checker for the word lookup mixer, bound to the top level.
// Uses pwlm_pkg.
module pwlm_checker import pwlm_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input in_item_t item
);
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n) done |-> busy)
		else $error("result outside an evaluation");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n) done |=> !done)
		else $error("result held two cycles");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n) done |=> !busy)
		else $error("busy after result");
	a_load_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && item.kind == KindLoad |=> !done ##1 !done)
		else $error("load gave a result");
endmodule

bind pow_word_lookup_mixer pwlm_checker u_chk (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done), .item(item)
);
